// ===== rtl/swqt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, request and status codes for the semaphore wait queue table.
// Used by swqt_front, swqt_back and semaphore_wait_queue_table.
package swqt_pkg;

  localparam int NPROC = 32;
  localparam int PID_W = 5;
  localparam int DEF_NUM_DESCRIPTORS = 32;
  localparam int DEF_KEY_WIDTH = 32;
  localparam int IN_KEY_W = 32;
  localparam int IN_DATA_W = 40;
  localparam int OUT_DATA_W = 8;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_OUT    = 2'd2;
  localparam logic [1:0] REQ_HEAD   = 2'd3;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NO_FREE   = 2'd1;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [1:0]       req;
    logic [PID_W-1:0] pid;
  } cmd_t;

endpackage

// ===== rtl/swqt_front.sv =====
`timescale 1ns / 1ps
// Front part: accepts request words, splits the fields and holds them in a
// two-entry queue for the back part. Depends on swqt_pkg.
module swqt_front #(
  parameter int KEY_WIDTH = swqt_pkg::DEF_KEY_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // req_type [1:0], sem_key [33:2], proc_id [38:34], zero [39]
  input  logic [swqt_pkg::IN_DATA_W-1:0] s_tdata,
  output logic                          cmd_valid,
  input  logic                          cmd_ready,
  output swqt_pkg::cmd_t                cmd,
  output logic [KEY_WIDTH-1:0]          cmd_key
);
  import swqt_pkg::*;

  cmd_t             ent_cmd [2];
  logic [KEY_WIDTH-1:0] ent_key [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic [63:0]      key_ext;
  cmd_t             in_cmd;
  logic             push;
  logic             pop;

  // The key is used in its low KEY_WIDTH bits, zero extended when wider.
  assign key_ext    = {32'd0, s_tdata[IN_KEY_W+1:2]};
  assign in_cmd.req = s_tdata[1:0];
  assign in_cmd.pid = s_tdata[IN_KEY_W+2+PID_W-1:IN_KEY_W+2];

  assign s_tready  = (count != 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign push      = s_tvalid && s_tready;
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = ent_cmd[rd_ptr];
  assign cmd_key   = ent_key[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        ent_cmd[wr_ptr] <= in_cmd;
        ent_key[wr_ptr] <= key_ext[KEY_WIDTH-1:0];
        wr_ptr          <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ===== rtl/swqt_back.sv =====
`timescale 1ns / 1ps
// Back part: descriptor table, per-process links and the sequencer that
// carries out one request at a time, plus the result register. Uses swqt_pkg.
module swqt_back #(
  parameter int NUM_DESCRIPTORS = swqt_pkg::DEF_NUM_DESCRIPTORS,
  parameter int KEY_WIDTH       = swqt_pkg::DEF_KEY_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cmd_valid,
  output logic                           cmd_ready,
  input  swqt_pkg::cmd_t                 cmd,
  input  logic [KEY_WIDTH-1:0]           cmd_key,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // status [1:0], proc_out [6:2], proc_out_valid [7]
  output logic [swqt_pkg::OUT_DATA_W-1:0] m_tdata
);
  import swqt_pkg::*;

  localparam int IDX_W = (NUM_DESCRIPTORS > 1) ? $clog2(NUM_DESCRIPTORS) : 1;
  localparam int CNT_W = $clog2(NUM_DESCRIPTORS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_DESCRIPTORS - 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_UL_RD  = 3'd1;
  localparam logic [2:0] ST_UL_DO  = 3'd2;
  localparam logic [2:0] ST_SCAN   = 3'd3;
  localparam logic [2:0] ST_HEAD   = 3'd4;
  localparam logic [2:0] ST_APPEND = 3'd5;
  localparam logic [2:0] ST_FINISH = 3'd6;

  // Descriptor memories: key, and head/tail packed as {head, tail}.
  logic [KEY_WIDTH-1:0] key_mem [NUM_DESCRIPTORS];
  logic [2*PID_W-1:0]   ht_mem  [NUM_DESCRIPTORS];
  logic [NUM_DESCRIPTORS-1:0] used;

  logic [PID_W-1:0] proc_next [NPROC];
  logic [PID_W-1:0] proc_prev [NPROC];
  logic [IDX_W-1:0] proc_slot [NPROC];
  logic [NPROC-1:0] blocked;

  logic [2:0]           state;
  logic [1:0]           op;
  logic [KEY_WIDTH-1:0] key_r;
  logic [PID_W-1:0]     pid_r;
  logic [PID_W-1:0]     ul_p;
  logic [IDX_W-1:0]     cur_slot;

  logic [CNT_W-1:0]     scan_cnt;
  logic                 cmp_vld;
  logic [IDX_W-1:0]     cmp_idx;
  logic                 free_found;
  logic [IDX_W-1:0]     free_idx;
  logic [KEY_WIDTH-1:0] key_q;
  logic [2*PID_W-1:0]   ht_q;

  logic [1:0]       res_status;
  logic [PID_W-1:0] res_proc;
  logic             res_pv;
  logic             out_valid;
  logic [1:0]       out_status;
  logic [PID_W-1:0] out_proc;
  logic             out_pv;

  logic             scan_issue;
  logic [IDX_W-1:0] key_raddr;
  logic [IDX_W-1:0] ht_raddr;
  logic             cmp_hit;
  logic             scan_last;
  logic             free_avail;
  logic [IDX_W-1:0] free_sel;
  logic [PID_W-1:0] ul_head;
  logic [PID_W-1:0] ul_tail;
  logic             is_head;
  logic             is_tail;
  logic             ht_we;
  logic [IDX_W-1:0] ht_waddr;
  logic [2*PID_W-1:0] ht_wdata;
  logic             key_we;

  assign scan_issue = (scan_cnt < CNT_W'(NUM_DESCRIPTORS));
  assign key_raddr  = scan_issue ? scan_cnt[IDX_W-1:0] : '0;
  assign ht_raddr   = (state == ST_SCAN) ? cmp_idx : cur_slot;
  assign cmp_hit    = cmp_vld && used[cmp_idx] && (key_q == key_r);
  assign scan_last  = cmp_vld && (cmp_idx == LAST_IDX);
  assign free_avail = free_found || (cmp_vld && !used[cmp_idx]);
  assign free_sel   = free_found ? free_idx : cmp_idx;

  assign ul_head = ht_q[2*PID_W-1:PID_W];
  assign ul_tail = ht_q[PID_W-1:0];
  assign is_head = (ul_head == ul_p);
  assign is_tail = (ul_tail == ul_p);

  assign cmd_ready = (state == ST_IDLE);
  assign m_tvalid  = out_valid;
  assign m_tdata   = {out_pv, out_proc, out_status};

  always_comb begin
    ht_we    = 1'b0;
    ht_waddr = cur_slot;
    ht_wdata = ht_q;
    key_we   = 1'b0;
    unique case (state)
      ST_UL_DO: begin
        if (is_head && !is_tail) begin
          ht_we    = 1'b1;
          ht_wdata = {proc_next[ul_p], ul_tail};
        end else if (is_tail && !is_head) begin
          ht_we    = 1'b1;
          ht_wdata = {ul_head, proc_prev[ul_p]};
        end
      end
      ST_APPEND: begin
        ht_we    = 1'b1;
        ht_wdata = {ul_head, pid_r};
      end
      ST_SCAN: begin
        if (!cmp_hit && scan_last && op == REQ_INSERT && free_avail) begin
          ht_we    = 1'b1;
          ht_waddr = free_sel;
          ht_wdata = {pid_r, pid_r};
          key_we   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    key_q <= key_mem[key_raddr];
    if (key_we) begin
      key_mem[free_sel] <= key_r;
    end
  end

  always_ff @(posedge clk) begin
    ht_q <= ht_mem[ht_raddr];
    if (ht_we) begin
      ht_mem[ht_waddr] <= ht_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      used      <= '0;
      blocked   <= '0;
      out_valid <= 1'b0;
    end else begin
      // In ST_FINISH the result register is loaded below instead.
      if (out_valid && m_tready && state != ST_FINISH) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            op         <= cmd.req;
            key_r      <= cmd_key;
            pid_r      <= cmd.pid;
            res_status <= STAT_OK;
            res_proc   <= '0;
            res_pv     <= 1'b0;
            ul_p       <= cmd.pid;
            cur_slot   <= proc_slot[cmd.pid];
            scan_cnt   <= '0;
            cmp_vld    <= 1'b0;
            free_found <= 1'b0;
            unique case (cmd.req)
              REQ_INSERT: begin
                // A process that is already blocked leaves its old queue first.
                state <= blocked[cmd.pid] ? ST_UL_RD : ST_SCAN;
              end
              REQ_OUT: begin
                if (blocked[cmd.pid]) begin
                  res_proc <= cmd.pid;
                  res_pv   <= 1'b1;
                  state    <= ST_UL_RD;
                end else begin
                  res_status <= STAT_NOT_FOUND;
                  state      <= ST_FINISH;
                end
              end
              REQ_REMOVE, REQ_HEAD: begin
                state <= ST_SCAN;
              end
              default: begin
                state <= ST_FINISH;
              end
            endcase
          end
        end
        ST_UL_RD: begin
          state <= ST_UL_DO;
        end
        ST_UL_DO: begin
          if (is_head && is_tail) begin
            used[cur_slot] <= 1'b0;
          end else if (!is_head && !is_tail) begin
            proc_next[proc_prev[ul_p]] <= proc_next[ul_p];
            proc_prev[proc_next[ul_p]] <= proc_prev[ul_p];
          end
          blocked[ul_p] <= 1'b0;
          scan_cnt      <= '0;
          cmp_vld       <= 1'b0;
          free_found    <= 1'b0;
          state         <= (op == REQ_INSERT) ? ST_SCAN : ST_FINISH;
        end
        ST_SCAN: begin
          // One key is read per cycle; its compare uses the registered read and index.
          cmp_vld  <= scan_issue;
          cmp_idx  <= scan_cnt[IDX_W-1:0];
          scan_cnt <= scan_issue ? scan_cnt + CNT_W'(1) : scan_cnt;
          if (cmp_vld && !used[cmp_idx] && !free_found) begin
            free_found <= 1'b1;
            free_idx   <= cmp_idx;
          end
          if (cmp_hit) begin
            cur_slot <= cmp_idx;
            state    <= (op == REQ_INSERT) ? ST_APPEND : ST_HEAD;
          end else if (scan_last) begin
            state <= ST_FINISH;
            if (op != REQ_INSERT) begin
              res_status <= STAT_NOT_FOUND;
            end else if (!free_avail) begin
              res_status <= STAT_NO_FREE;
            end else begin
              used[free_sel]   <= 1'b1;
              proc_slot[pid_r] <= free_sel;
              blocked[pid_r]   <= 1'b1;
            end
          end
        end
        ST_HEAD: begin
          res_proc <= ul_head;
          res_pv   <= 1'b1;
          ul_p     <= ul_head;
          state    <= (op == REQ_REMOVE) ? ST_UL_RD : ST_FINISH;
        end
        ST_APPEND: begin
          proc_next[ul_tail] <= pid_r;
          proc_prev[pid_r]   <= ul_tail;
          proc_slot[pid_r]   <= cur_slot;
          blocked[pid_r]     <= 1'b1;
          state              <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!out_valid || m_tready) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_proc   <= res_proc;
            out_pv     <= res_pv;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_unlink_blocked: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UL_DO) |-> blocked[ul_p])
    else $error("unlink of a process that is not blocked");

  a_append_used: assert property (@(posedge clk) disable iff (rst)
    (state == ST_APPEND) |-> used[cur_slot])
    else $error("append to a free descriptor");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (scan_cnt <= CNT_W'(NUM_DESCRIPTORS)))
    else $error("key scan ran past the table");

  a_hit_ends_scan: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && cmp_hit) |=> (state == ST_APPEND || state == ST_HEAD))
    else $error("key hit did not end the scan");

endmodule

// ===== rtl/semaphore_wait_queue_table.sv =====
`timescale 1ns / 1ps
// Semaphore wait queue table: up to NUM_DESCRIPTORS semaphore descriptors,
// each with a FIFO of blocked process ids. Top level; uses swqt_pkg,
// swqt_front and swqt_back.
//
// Usage: each request word on the s_ side (insert, remove head, take out a
// process, peek head) gives exactly one result word on the m_ side, in order.
// Requests are held in a two-entry queue, so up to two more words are taken
// while a request is being worked on or a result waits on m_tready.
// The back part works on one request at a time. A request that looks up a
// key scans the key memory one descriptor per cycle and stops at a hit (a
// remove then unlinks the head); a miss or a new descriptor scans the whole
// table. An insert of a process that is already blocked unlinks it first.
// A take out request needs no scan. The scan is what sets throughput.
// Reset clears all descriptors and all blocked flags at once; no clearing
// pass is needed. While m_tready is low the result is held and the queue
// fills, after which s_tready drops.
module semaphore_wait_queue_table #(
  parameter int NUM_DESCRIPTORS = swqt_pkg::DEF_NUM_DESCRIPTORS,
  parameter int KEY_WIDTH       = swqt_pkg::DEF_KEY_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // req_type [1:0], sem_key [33:2], proc_id [38:34], zero [39]
  input  logic [swqt_pkg::IN_DATA_W-1:0]  s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // status [1:0], proc_out [6:2], proc_out_valid [7]
  output logic [swqt_pkg::OUT_DATA_W-1:0] m_tdata
);
  import swqt_pkg::*;

  logic                 cmd_valid;
  logic                 cmd_ready;
  cmd_t                 cmd;
  logic [KEY_WIDTH-1:0] cmd_key;

  swqt_front #(
    .KEY_WIDTH (KEY_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .cmd_key   (cmd_key)
  );

  swqt_back #(
    .NUM_DESCRIPTORS (NUM_DESCRIPTORS),
    .KEY_WIDTH       (KEY_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .cmd_key   (cmd_key),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule
